[sv/assert_macros.svh]
// Assertion macros shared by the scanner RTL.
// Simulation builds get checking assertions; synthesis builds get empty macros.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising clock edge outside reset.
`define DSS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication.
`define DSS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define DSS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define DSS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[sv/dss_pkg.sv]
// Types and constants for the disc serial scanner.
// No dependencies; used by all scanner modules.
`default_nettype none
package dss_pkg;

	localparam int unsigned WIN_LEN      = 11;
	localparam int unsigned COUNT_W      = 18;
	localparam int unsigned PREFIX_COUNT = 24;

	localparam logic [COUNT_W-1:0] LIMIT_RESET = 18'd204800;

	// Register index of scan_limit.
	localparam logic REG_SCAN_LIMIT = 1'b0;

	typedef logic [31:0] prefix_t;
	typedef prefix_t prefix_table_t [PREFIX_COUNT];

	localparam prefix_table_t PREFIX_TABLE = '{
		"SCUS", "SLUS", "SPUS", "PUPX", "SCES", "SLES", "SCED", "SLED",
		"PEPX", "SCPS", "SCPM", "SLPS", "SLPM", "SIPS", "ESPM", "SLKA",
		"PAPX", "PCPX", "PCPD", "PTPX", "PBPX", "CPCS", "SCAJ", "SCZS"
	};

	typedef struct packed {
		logic        has_result;
		logic        found;
		logic [31:0] letters;
		logic [39:0] digits;
	} result_t;

	typedef struct packed {
		logic               done;
		logic [COUNT_W-1:0] count;
	} status_t;

endpackage
`default_nettype wire

[sv/dss_prefix_match.sv]
// Parallel compare of four letters against the fixed prefix table.
// Depends on dss_pkg.
`default_nettype none
module dss_prefix_match (
	input  wire logic [31:0] letters,
	output logic             hit
);

	always_comb begin
		hit = 1'b0;
		for (int k = 0; k < dss_pkg::PREFIX_COUNT; k++) begin
			if (letters == dss_pkg::PREFIX_TABLE[k]) begin
				hit = 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

[sv/dss_scan_core.sv]
// Scan state (byte window, byte count, idle flag) and the per-byte decision.
// Depends on dss_pkg and dss_prefix_match.
`default_nettype none
module dss_scan_core (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         step,
	input  wire logic [7:0]                   data_byte,
	input  wire logic                         first_byte,
	input  wire logic                         last_byte,
	input  wire logic [dss_pkg::COUNT_W-1:0]  scan_limit,
	output dss_pkg::result_t                  result,
	output dss_pkg::status_t                  status
);

	logic [7:0]                  window_q [dss_pkg::WIN_LEN];
	logic [dss_pkg::COUNT_W-1:0] count_q;
	logic                        done_q;

	logic [7:0]                  window_eff [dss_pkg::WIN_LEN];
	logic [7:0]                  window_d   [dss_pkg::WIN_LEN];
	logic [dss_pkg::COUNT_W-1:0] count_eff;
	logic [dss_pkg::COUNT_W-1:0] count_d;
	logic                        done_eff;
	logic                        take;
	logic                        hit;
	logic                        match;
	logic                        not_found;
	logic [31:0]                 letters;

	assign letters = {window_d[0], window_d[1], window_d[2], window_d[3]};

	dss_prefix_match u_match (
		.letters (letters),
		.hit     (hit)
	);

	always_comb begin
		// A first byte restarts the scan from an empty window.
		for (int i = 0; i < dss_pkg::WIN_LEN; i++) begin
			window_eff[i] = first_byte ? 8'h00 : window_q[i];
		end
		count_eff = first_byte ? '0 : count_q;
		done_eff  = first_byte ? 1'b0 : done_q;

		take = !done_eff && (count_eff < scan_limit);

		for (int i = 0; i < dss_pkg::WIN_LEN - 1; i++) begin
			window_d[i] = take ? window_eff[i+1] : window_eff[i];
		end
		window_d[dss_pkg::WIN_LEN-1] = take ? data_byte : window_eff[dss_pkg::WIN_LEN-1];
		count_d = take ? count_eff + 1'b1 : count_eff;

		match = take && (count_d >= dss_pkg::COUNT_W'(dss_pkg::WIN_LEN)) && hit;
		not_found = !done_eff && !match && (last_byte || (count_d >= scan_limit));

		result.has_result = match || not_found;
		result.found      = match;
		result.letters    = match ? letters : '0;
		result.digits     = match ? {window_d[5], window_d[6], window_d[7],
			window_d[9], window_d[10]} : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < dss_pkg::WIN_LEN; i++) begin
				window_q[i] <= 8'h00;
			end
			count_q <= '0;
			done_q  <= 1'b1;
		end else if (step) begin
			window_q <= window_d;
			count_q  <= count_d;
			done_q   <= done_eff || result.has_result;
		end
	end

	assign status.done  = done_q;
	assign status.count = count_q;

endmodule
`default_nettype wire

[sv/disc_serial_scanner.sv]
// Disc serial scanner: one byte per cycle in unless stalled; one result per image at most.
// The byte that ends the scan passes the input register, then raises out_valid.
// Throughput: one byte per cycle while no result waits; 11-byte window, parallel compares.
// Reset: window and byte count cleared, scan idle until a first byte, scan_limit 204800.
// Depends on dss_pkg, dss_scan_core, dss_prefix_match and assert_macros.svh.
`include "assert_macros.svh"
`default_nettype none
module disc_serial_scanner (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Byte stream.
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        first_byte,
	input  wire logic        last_byte,
	// Scan result.
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             found,
	output logic [31:0]      id_letters,
	output logic [39:0]      id_digits,
	// Configuration port.
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	// The scan limit register. The APB port never stalls, and the single
	// register is decoded from the word address bit.
	logic [dss_pkg::COUNT_W-1:0] scan_limit_q;
	logic                        reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[2] == dss_pkg::REG_SCAN_LIMIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_limit_q <= dss_pkg::LIMIT_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			scan_limit_q <= pwdata[dss_pkg::COUNT_W-1:0];
		end
	end

	assign prdata = reg_sel ? {{(32 - dss_pkg::COUNT_W){1'b0}}, scan_limit_q} : '0;

	// Input register. The byte held here is scanned once the output register
	// is free or being emptied in the same cycle; a new byte enters whenever
	// the held one moves on, so bytes flow at one per cycle while the output is not held.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       first_s1;
	logic       last_s1;
	logic       advance;

	dss_pkg::result_t result;
	dss_pkg::status_t status;

	assign advance  = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1  <= data_byte;
			first_s1 <= first_byte;
			last_s1  <= last_byte;
		end
	end

	// The window, byte count and idle flag advance with each scanned byte.
	dss_scan_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.data_byte  (byte_s1),
		.first_byte (first_s1),
		.last_byte  (last_s1),
		.scan_limit (scan_limit_q),
		.result     (result),
		.status     (status)
	);

	// Output register. It holds a finished result until it is taken while the
	// input register keeps collecting the next byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= result.has_result;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && result.has_result) begin
			found      <= result.found;
			id_letters <= result.letters;
			id_digits  <= result.digits;
		end
	end

	// A not-found result carries zero letters and digits.
	`DSS_ASSERT_IMP(a_notfound_zero, clk, arst_n, out_valid && !found, id_letters == '0 && id_digits == '0)
	// A scanned byte that ends the scan shows up in the output register next cycle.
	`DSS_ASSERT_NXT(a_result_lands, clk, arst_n, advance && result.has_result, out_valid)
	// After any result the scan goes idle until a first byte.
	`DSS_ASSERT_NXT(a_idle_after_result, clk, arst_n, advance && result.has_result, status.done)
	// The byte stream is held back only while a byte waits in the input register.
	`DSS_ASSERT_IMP(a_ready_low_holds, clk, arst_n, !in_ready, valid_s1 && out_valid && !out_ready)

endmodule
`default_nettype wire
